>>> design/hsvb_pkg.sv
// Package for the HSV to RGB unit with global brightness.
// Holds field widths, hue sector codes and the divide-by-255 helper.
// No dependencies.
package hsvb_pkg;

  localparam int unsigned HueW   = 16;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned ProdW  = 2 * ChanW;
  localparam int unsigned SectW  = 3;
  localparam int unsigned Stages = 6;

  localparam logic [ChanW-1:0] FullScale      = 8'd255;
  localparam logic [ChanW-1:0] BrightnessRst  = 8'd255;
  localparam logic [HueW:0]    HueSpan        = 17'h1_0000;

  // Hue sectors, one sixth of the circle each
  localparam logic [SectW-1:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [SectW-1:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [SectW-1:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [SectW-1:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [SectW-1:0] SEC_BLUE_MAGENTA  = 3'd4;
  localparam logic [SectW-1:0] SEC_MAGENTA_RED   = 3'd5;

  // floor(x / 255) for x <= 255*255: estimate by x/256 + x/65536, which is
  // low by at most one, then fix with a single compare on the remainder.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0]   sum;
    logic [ChanW-1:0] est;
    logic [ProdW-1:0] back;
    logic [ProdW-1:0] rem;
    sum  = {1'b0, x} + {{(ProdW-ChanW+1){1'b0}}, x[ProdW-1:ChanW]};
    est  = sum[ProdW-1:ChanW];
    back = {est, {ChanW{1'b0}}} - {{ChanW{1'b0}}, est};
    rem  = x - back;
    if (rem >= {{ChanW{1'b0}}, FullScale}) begin
      est = est + 8'd1;
    end
    return est;
  endfunction

endpackage

>>> design/hsv_to_rgb_with_brightness_unit.sv
// HSV to RGB conversion with global brightness, six-stage pipeline.
// Depends on hsvb_pkg (widths, sector codes, div255).
//
// Usage:
//   Input stream s_axis_*: one pixel per transfer, tdata carries hue,
//   saturation and level. Output stream m_axis_*: one RGB triple per
//   input pixel, in the same order.
//   Configuration: brightness is written by cfg_we_i / cfg_wdata_i;
//   write it only while no pixel is in flight.
//   Path: the input transfer edge loads stage 1; the pixel then moves
//   through stages 2 to 6, and m_axis_tvalid_o is the valid bit of
//   stage 6, whose registers drive m_axis_tdata_o.
//   Throughput: one pixel per cycle while m_axis_tready_i is high, as every
//   stage then takes a new pixel each cycle; each stage holds at most one
//   rank of multiplies (up to 17 by 8 bits) or of divide-by-255 fixups.
//   Stalls: every stage advances when it is empty or the stage after it
//   advances, so bubbles collapse and the input keeps taking transfers
//   while a finished result waits; when all stages hold data and the
//   receiver holds m_axis_tready_i low, s_axis_tready_o drops and
//   everything holds.
//   Reset: asynchronous, active low; empties the pipeline and sets
//   brightness to 255 (unity scale).
module hsv_to_rgb_with_brightness_unit
  import hsvb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // brightness
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // [15:0] hue, [23:16] saturation, [31:24] level
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // [7:0] red, [15:8] green, [23:16] blue
);

  logic [ChanW-1:0] brightness_q;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;

  // Stage advance: a stage loads when it is empty or its content moves on
  always_comb begin
    en[Stages-1] = !v_q[Stages-1] || m_axis_tready_i;
    for (int k = Stages-2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[Stages-1];

  logic in_fire;
  logic out_fire;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= BrightnessRst;
    end else if (cfg_we_i) begin
      brightness_q <= cfg_wdata_i;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------- Stage 1: sector and fraction from hue*6
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat_in;
  logic [ChanW-1:0] lvl_in;
  logic [HueW+2:0]  hue_x6;

  assign hue    = s_axis_tdata_i[15:0];
  assign sat_in = s_axis_tdata_i[23:16];
  assign lvl_in = s_axis_tdata_i[31:24];
  assign hue_x6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  logic [SectW-1:0] sect1_q;
  logic [HueW-1:0]  frac1_q;
  logic [ChanW-1:0] sat1_q;
  logic [ChanW-1:0] lvl1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sect1_q <= hue_x6[HueW+2:HueW];
      frac1_q <= hue_x6[HueW-1:0];
      sat1_q  <= sat_in;
      lvl1_q  <= lvl_in;
    end
  end

  // ---------------- Stage 2: fraction times saturation, p product
  logic [HueW:0]        frac_inv;
  logic [HueW+ChanW-1:0] fs_prod;
  logic [HueW+ChanW:0]   ts_prod;
  logic [ChanW-1:0]     sat_inv;

  assign frac_inv = HueSpan - {1'b0, frac1_q};
  assign fs_prod  = frac1_q * sat1_q;
  assign ts_prod  = frac_inv * sat1_q;
  assign sat_inv  = FullScale - sat1_q;

  logic [SectW-1:0] sect2_q;
  logic [ChanW-1:0] lvl2_q;
  logic [ChanW-1:0] fs2_q;
  logic [ChanW-1:0] ts2_q;
  logic [ProdW-1:0] pprod2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sect2_q  <= sect1_q;
      lvl2_q   <= lvl1_q;
      fs2_q    <= fs_prod[HueW+ChanW-1:HueW];
      // product never exceeds 65536*255, so bit HueW+ChanW is zero
      ts2_q    <= ts_prod[HueW+ChanW-1:HueW];
      pprod2_q <= lvl1_q * sat_inv;
    end
  end

  // ---------------- Stage 3: q and t products
  logic [ChanW-1:0] q_fac;
  logic [ChanW-1:0] t_fac;
  assign q_fac = FullScale - fs2_q;
  assign t_fac = FullScale - ts2_q;

  logic [SectW-1:0] sect3_q;
  logic [ChanW-1:0] lvl3_q;
  logic [ProdW-1:0] pprod3_q;
  logic [ProdW-1:0] qprod3_q;
  logic [ProdW-1:0] tprod3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sect3_q  <= sect2_q;
      lvl3_q   <= lvl2_q;
      pprod3_q <= pprod2_q;
      qprod3_q <= lvl2_q * q_fac;
      tprod3_q <= lvl2_q * t_fac;
    end
  end

  // ---------------- Stage 4: divide p, q, t by 255
  logic [SectW-1:0] sect4_q;
  logic [ChanW-1:0] lvl4_q;
  logic [ChanW-1:0] p4_q;
  logic [ChanW-1:0] q4_q;
  logic [ChanW-1:0] t4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sect4_q <= sect3_q;
      lvl4_q  <= lvl3_q;
      p4_q    <= div255(pprod3_q);
      q4_q    <= div255(qprod3_q);
      t4_q    <= div255(tprod3_q);
    end
  end

  // ---------------- Stage 5: route by sector, scale by brightness
  logic [ChanW-1:0] red_sel;
  logic [ChanW-1:0] grn_sel;
  logic [ChanW-1:0] blu_sel;

  always_comb begin
    unique case (sect4_q)
      SEC_RED_YELLOW: begin
        red_sel = lvl4_q; grn_sel = t4_q;   blu_sel = p4_q;
      end
      SEC_YELLOW_GREEN: begin
        red_sel = q4_q;   grn_sel = lvl4_q; blu_sel = p4_q;
      end
      SEC_GREEN_CYAN: begin
        red_sel = p4_q;   grn_sel = lvl4_q; blu_sel = t4_q;
      end
      SEC_CYAN_BLUE: begin
        red_sel = p4_q;   grn_sel = q4_q;   blu_sel = lvl4_q;
      end
      SEC_BLUE_MAGENTA: begin
        red_sel = t4_q;   grn_sel = p4_q;   blu_sel = lvl4_q;
      end
      SEC_MAGENTA_RED: begin
        red_sel = lvl4_q; grn_sel = p4_q;   blu_sel = q4_q;
      end
      default: begin
        red_sel = lvl4_q; grn_sel = p4_q;   blu_sel = q4_q;
      end
    endcase
  end

  logic [ProdW-1:0] rprod5_q;
  logic [ProdW-1:0] gprod5_q;
  logic [ProdW-1:0] bprod5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      rprod5_q <= red_sel * brightness_q;
      gprod5_q <= grn_sel * brightness_q;
      bprod5_q <= blu_sel * brightness_q;
    end
  end

  // ---------------- Stage 6: divide by 255, output register
  logic [ChanW-1:0] red6_q;
  logic [ChanW-1:0] grn6_q;
  logic [ChanW-1:0] blu6_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      red6_q <= div255(rprod5_q);
      grn6_q <= div255(gprod5_q);
      blu6_q <= div255(bprod5_q);
    end
  end

  assign m_axis_tdata_o = {blu6_q, grn6_q, red6_q};

  // ---------------- Assertions
  // Occupancy tracks transfers: one in adds a pixel, one out removes one
  assert property (@(posedge clk_i)
    (rst_ni && $past(rst_ni)) |->
      ($countones(v_q) == $past($countones(v_q)) + $past(in_fire) - $past(out_fire)))
    else $error("pipeline occupancy does not match transfers");

  // An empty output stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[Stages-1] |-> s_axis_tready_o)
    else $error("input stalled with empty output stage");

  // A full, stalled pipeline refuses input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while pipeline full and stalled");

endmodule
